>>> rtl/core/iog_pkg.sv
// Package for the icosahedral orbit generator: sizes, the signed permutation
// type and the constant group table built from its two generators.
// No dependencies.
package iog_pkg;

  localparam int GROUP_ORDER    = 60;
  localparam int WORD_LIMIT     = 10000;
  localparam int DIM            = 6;
  localparam int COMP_WIDTH_DEF = 16;
  localparam int COL_W          = 3;
  localparam int ADDR_W         = $clog2(GROUP_ORDER);
  localparam int CNT_W          = $clog2(GROUP_ORDER + 1);

  // Row r of a matrix picks component col[r], negated when neg[r] is set.
  typedef struct packed {
    logic [DIM-1:0][COL_W-1:0] col;
    logic [DIM-1:0]            neg;
  } perm_t;

  typedef perm_t [GROUP_ORDER-1:0] rom_t;

  typedef struct packed {
    rom_t           entries;
    logic [CNT_W:0] size;
  } rom_build_t;

  localparam perm_t GEN_A = '{col: '{3'd3, 3'd2, 3'd5, 3'd4, 3'd1, 3'd0}, neg: 6'b000011};
  localparam perm_t GEN_B = '{col: '{3'd4, 3'd3, 3'd5, 3'd0, 3'd2, 3'd1}, neg: 6'b000011};

  function automatic perm_t perm_mul(perm_t x, perm_t y);
    perm_t z;
    z = '0;
    for (int r = 0; r < DIM; r++) begin
      z.col[r] = y.col[x.col[r]];
      z.neg[r] = x.neg[r] ^ y.neg[x.col[r]];
    end
    return z;
  endfunction

  // Walks binary words over the generators, least significant bit first,
  // and keeps each new product until the table is full.
  function automatic rom_build_t rom_build();
    rom_build_t  res;
    perm_t       cur;
    int unsigned size;
    int unsigned id;
    bit          found;
    res  = '0;
    size = 0;
    for (int i = 0; i < WORD_LIMIT && size < GROUP_ORDER; i++) begin
      for (int r = 0; r < DIM; r++) begin
        cur.col[r] = COL_W'(r);
        cur.neg[r] = 1'b0;
      end
      id = i;
      do begin
        cur = perm_mul(cur, id[0] ? GEN_B : GEN_A);
        id  = id >> 1;
      end while (id > 0);
      found = 1'b0;
      for (int e = 0; e < GROUP_ORDER; e++) begin
        if (e < size && res.entries[e] == cur) begin
          found = 1'b1;
        end
      end
      if (!found) begin
        res.entries[size] = cur;
        size++;
      end
    end
    res.size = (CNT_W + 1)'(size);
    return res;
  endfunction

  localparam rom_build_t ROM_BUILD = rom_build();
  localparam rom_t       ROM       = ROM_BUILD.entries;
  localparam int         ROM_SIZE  = int'(ROM_BUILD.size);

endpackage

>>> rtl/core/iog_if.sv
// Valid/ready channel interfaces of the icosahedral orbit generator:
// the input vector channel and the orbit image channel.
// No dependencies.
interface iog_vec_if #(parameter int W = 16) ();
  logic         valid;
  logic         ready;
  logic [W-1:0] comp_0;
  logic [W-1:0] comp_1;
  logic [W-1:0] comp_2;
  logic [W-1:0] comp_3;
  logic [W-1:0] comp_4;
  logic [W-1:0] comp_5;

  modport source (output valid, comp_0, comp_1, comp_2, comp_3, comp_4, comp_5,
                  input ready);
  modport sink (input valid, comp_0, comp_1, comp_2, comp_3, comp_4, comp_5,
                output ready);
endinterface

interface iog_img_if #(parameter int W = 16) ();
  logic         valid;
  logic         ready;
  logic [W-1:0] img_0;
  logic [W-1:0] img_1;
  logic [W-1:0] img_2;
  logic [W-1:0] img_3;
  logic [W-1:0] img_4;
  logic [W-1:0] img_5;
  logic         last_image;

  modport source (output valid, img_0, img_1, img_2, img_3, img_4, img_5, last_image,
                  input ready);
  modport sink (input valid, img_0, img_1, img_2, img_3, img_4, img_5, last_image,
                output ready);
endinterface

>>> rtl/core/iog_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module iog_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 60
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/icosahedral_orbit_generator.sv
// Icosahedral orbit generator top level: sequencer, shared image compare
// and the orbit store. Depends on iog_pkg, iog_if and iog_ram.
//
// Usage: a 6-component signed vector is transferred on the vec channel.
// The block walks the 60 group elements in table order; for each one it
// forms the signed permuted image (negating the most negative value
// saturates), and compares it, one stored image per cycle through the
// single 96-bit comparator, against the images already kept for this
// vector. Each new image is written to the orbit store and sent on the
// orbit channel; the final image of a vector carries last_image = 1.
// Every vector yields between 1 and 60 images.
// An element whose image is new is compared against all images kept so
// far (the first element skips the scan); for a duplicate the scan stops
// at the first kept image that matches. A vector is taken only in the
// idle state, so vec.ready is high only between vectors.
// One image is held back until the next one is found, so the last_image
// flag is known when it is sent. The output register keeps a transfer
// waiting while the sequencer goes on; a stalled receiver stops the walk
// only when another image has to be sent.
// Reset clears the sequencer, the counters and the output valid; the orbit
// store needs no clearing, since only entries written for the current
// vector are read.
module icosahedral_orbit_generator #(
  parameter int COMP_WIDTH = iog_pkg::COMP_WIDTH_DEF
) (
  input logic        clk,
  input logic        rst,
  iog_vec_if.sink    vec,
  iog_img_if.source  orbit
);
  import iog_pkg::*;

  localparam int IMG_W = DIM * COMP_WIDTH;

  typedef enum logic [2:0] {IDLE, CALC, SCAN, EMIT, NEXT, FLUSH} state_t;

  typedef logic [DIM-1:0][COMP_WIDTH-1:0] img_t;

  state_t             state;
  img_t               v;
  img_t               img;
  img_t               img_next;
  img_t               pend_img;
  logic               pend_vld;
  img_t               o_img;
  logic               o_valid;
  logic               o_last;
  logic               o_load;
  logic [ADDR_W-1:0]  elem;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   scan_idx;
  logic               chk_vld;
  logic               chk_last;
  logic               issue_ok;
  logic               hit;
  logic               out_free;
  logic [IMG_W-1:0]   rdata;
  logic               ram_we;

  function automatic logic [COMP_WIDTH-1:0] pick(img_t x, logic [COL_W-1:0] c);
    logic [COMP_WIDTH-1:0] s;
    case (c)
      3'd0:    s = x[0];
      3'd1:    s = x[1];
      3'd2:    s = x[2];
      3'd3:    s = x[3];
      3'd4:    s = x[4];
      3'd5:    s = x[5];
      default: s = x[0];
    endcase
    return s;
  endfunction

  // Image of the current element; negating the minimum saturates.
  always_comb begin
    perm_t                 p;
    logic [COMP_WIDTH-1:0] x;
    p        = ROM[elem];
    img_next = '0;
    for (int r = 0; r < DIM; r++) begin
      x = pick(v, p.col[r]);
      if (!p.neg[r]) begin
        img_next[r] = x;
      end else if (x == {1'b1, {(COMP_WIDTH-1){1'b0}}}) begin
        img_next[r] = {1'b0, {(COMP_WIDTH-1){1'b1}}};
      end else begin
        img_next[r] = -x;
      end
    end
  end

  assign issue_ok = (scan_idx != count);
  assign hit      = chk_vld && (rdata == img);
  assign out_free = !o_valid || orbit.ready;
  assign ram_we   = (state == EMIT) && !(pend_vld && !out_free);
  // The output register takes a new image in this cycle.
  assign o_load   = out_free && (((state == EMIT) && pend_vld) || (state == FLUSH));

  iog_ram #(
    .WIDTH (IMG_W),
    .DEPTH (GROUP_ORDER)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[ADDR_W-1:0]),
    .wdata (img),
    .raddr (scan_idx[ADDR_W-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      pend_vld <= 1'b0;
      o_valid  <= 1'b0;
      elem     <= '0;
      count    <= '0;
      scan_idx <= '0;
      chk_vld  <= 1'b0;
      chk_last <= 1'b0;
    end else begin
      if (o_load) begin
        o_valid <= 1'b1;
      end else if (orbit.ready) begin
        o_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (vec.valid) begin
            v     <= {vec.comp_5, vec.comp_4, vec.comp_3,
                      vec.comp_2, vec.comp_1, vec.comp_0};
            elem  <= '0;
            count <= '0;
            state <= CALC;
          end
        end
        CALC: begin
          img      <= img_next;
          scan_idx <= '0;
          chk_vld  <= 1'b0;
          chk_last <= 1'b0;
          state    <= (count == '0) ? EMIT : SCAN;
        end
        SCAN: begin
          if (hit) begin
            state <= NEXT;
          end else if (chk_vld && chk_last) begin
            state <= EMIT;
          end else begin
            chk_vld  <= issue_ok;
            chk_last <= (scan_idx == count - CNT_W'(1));
            if (issue_ok) begin
              scan_idx <= scan_idx + CNT_W'(1);
            end
          end
        end
        EMIT: begin
          if (!(pend_vld && !out_free)) begin
            if (pend_vld) begin
              o_img   <= pend_img;
              o_last  <= 1'b0;
            end
            pend_img <= img;
            pend_vld <= 1'b1;
            count    <= count + CNT_W'(1);
            state    <= NEXT;
          end
        end
        NEXT: begin
          if (elem == ADDR_W'(ROM_SIZE - 1)) begin
            state <= FLUSH;
          end else begin
            elem  <= elem + ADDR_W'(1);
            state <= CALC;
          end
        end
        FLUSH: begin
          if (out_free) begin
            o_img    <= pend_img;
            o_last   <= 1'b1;
            pend_vld <= 1'b0;
            state    <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  assign vec.ready        = (state == IDLE);
  assign orbit.valid      = o_valid;
  assign orbit.img_0      = o_img[0];
  assign orbit.img_1      = o_img[1];
  assign orbit.img_2      = o_img[2];
  assign orbit.img_3      = o_img[3];
  assign orbit.img_4      = o_img[4];
  assign orbit.img_5      = o_img[5];
  assign orbit.last_image = o_last;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(GROUP_ORDER))
    else $error("orbit count exceeds the group order");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == SCAN |-> scan_idx <= count)
    else $error("store scan ran past the kept images");

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    vec.ready |-> !pend_vld)
    else $error("an image is still held back while a new vector is taken");

  a_write_room: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> count < CNT_W'(GROUP_ORDER))
    else $error("orbit store written beyond its depth");

  a_first_new: assert property (@(posedge clk) disable iff (rst)
    (state == CALC && count == '0) |=> state == EMIT)
    else $error("first image of a vector was not kept");

endmodule

>>> dv/iog_orbit_checker.sv
`timescale 1ns / 100ps
// Orbit checker for the icosahedral orbit generator: watches both channels,
// predicts the distinct images of every accepted vector and compares them.
// Depends on iog_pkg and the channel interfaces in iog_if.
module iog_orbit_checker (
  input  logic        clk,
  input  logic        rst,
  iog_vec_if          vec,
  iog_img_if          orbit,
  output int unsigned failures,
  output int unsigned pending
);
  import iog_pkg::*;

  localparam int W       = COMP_WIDTH_DEF;
  localparam int MAX_POS = (1 << (W - 1)) - 1;

  typedef logic [DIM-1:0][W-1:0] image_t;

  typedef struct packed {
    image_t img;
    logic   last;
  } orbit_img_t;

  // Row r of element e takes component elem_src[e][r], negated if elem_flip is set.
  int          elem_src  [GROUP_ORDER][DIM];
  bit          elem_flip [GROUP_ORDER][DIM];
  int unsigned elem_count;

  orbit_img_t expected_images [$];

  initial begin : group_build
    int          gen_src  [2][DIM];
    bit          gen_flip [2][DIM];
    int          cur_src  [DIM];
    int          nxt_src  [DIM];
    bit          cur_flip [DIM];
    bit          nxt_flip [DIM];
    int unsigned word;
    int unsigned sel;
    bit          seen;
    bit          same;
    gen_src  = '{'{0, 1, 4, 5, 2, 3}, '{1, 2, 0, 5, 3, 4}};
    gen_flip = '{'{1, 1, 0, 0, 0, 0}, '{1, 1, 0, 0, 0, 0}};
    elem_count = 0;
    for (int i = 0; i < WORD_LIMIT && elem_count < GROUP_ORDER; i++) begin
      for (int r = 0; r < DIM; r++) begin
        cur_src[r]  = r;
        cur_flip[r] = 1'b0;
      end
      // Bits of the word index, least significant first: 0 picks A, 1 picks B.
      word = i;
      do begin
        sel = word & 1;
        for (int r = 0; r < DIM; r++) begin
          nxt_src[r]  = gen_src[sel][cur_src[r]];
          nxt_flip[r] = cur_flip[r] ^ gen_flip[sel][cur_src[r]];
        end
        cur_src  = nxt_src;
        cur_flip = nxt_flip;
        word     = word >> 1;
      end while (word != 0);
      seen = 1'b0;
      for (int e = 0; e < elem_count; e++) begin
        same = 1'b1;
        for (int r = 0; r < DIM; r++) begin
          if (elem_src[e][r] != cur_src[r] || elem_flip[e][r] != cur_flip[r]) begin
            same = 1'b0;
          end
        end
        if (same) begin
          seen = 1'b1;
        end
      end
      if (!seen) begin
        elem_src[elem_count]  = cur_src;
        elem_flip[elem_count] = cur_flip;
        elem_count++;
      end
    end
  end

  function automatic void predict_orbit(image_t vin);
    image_t     kept [$];
    image_t     img;
    orbit_img_t entry;
    int         x;
    bit         dup;
    for (int e = 0; e < elem_count; e++) begin
      for (int r = 0; r < DIM; r++) begin
        x = $signed(vin[elem_src[e][r]]);
        if (elem_flip[e][r]) begin
          x = -x;
        end
        // Negating the most negative value clips to the largest positive one.
        if (x > MAX_POS) begin
          x = MAX_POS;
        end
        img[r] = x[W-1:0];
      end
      dup = 1'b0;
      foreach (kept[s]) begin
        if (kept[s] == img) begin
          dup = 1'b1;
        end
      end
      if (!dup) begin
        kept.insert(kept.size(), img);
      end
    end
    foreach (kept[s]) begin
      entry.img  = kept[s];
      entry.last = (s == kept.size() - 1);
      expected_images.insert(expected_images.size(), entry);
    end
  endfunction

  always @(posedge clk) begin
    orbit_img_t  want;
    image_t      got;
    int unsigned errs;
    errs = 0;
    if (rst) begin
      failures <= 0;
      pending  <= 0;
    end else begin
      if (vec.valid && vec.ready) begin
        predict_orbit({vec.comp_5, vec.comp_4, vec.comp_3, vec.comp_2, vec.comp_1, vec.comp_0});
      end
      if (orbit.valid && orbit.ready) begin
        got = {orbit.img_5, orbit.img_4, orbit.img_3, orbit.img_2, orbit.img_1, orbit.img_0};
        if (expected_images.size() == 0) begin
          $display("%0t: unexpected image transfer: expected none, got %h last_image %b",
                   $time, got, orbit.last_image);
          errs++;
        end else begin
          want = expected_images.pop_front();
          for (int r = 0; r < DIM; r++) begin
            if (got[r] !== want.img[r]) begin
              $display("%0t: img_%0d expected %0d got %0d", $time, r,
                       $signed(want.img[r]), $signed(got[r]));
              errs++;
            end
          end
          if (orbit.last_image !== want.last) begin
            $display("%0t: last_image expected %b got %b", $time, want.last,
                     orbit.last_image);
            errs++;
          end
        end
      end
      failures <= failures + errs;
      pending  <= expected_images.size();
    end
  end

endmodule

>>> dv/tb_icosahedral_orbit_generator.sv
`timescale 1ns / 100ps
// Top of the icosahedral orbit generator testbench: clock, reset, vector
// stimulus, image receiver with random stalls and the verdict.
// Depends on iog_pkg, iog_if, the block and iog_orbit_checker.
module tb_icosahedral_orbit_generator;
  import iog_pkg::*;

  localparam int W            = COMP_WIDTH_DEF;
  localparam int RANDOM_ITEMS = 250;
  localparam int HOLD_AT      = 500;
  localparam int HOLD_CYCLES  = 3000;
  localparam int CYCLE_LIMIT  = 6_000_000;
  localparam int DRAIN_CYCLES = 200;

  typedef logic [DIM-1:0][W-1:0] image_t;

  logic        clk;
  logic        rst;
  int unsigned failures;
  int unsigned pending;
  int unsigned cycle_count;
  int unsigned image_transfers;
  bit          send_calm;
  bit          recv_calm;

  iog_vec_if #(.W(W)) vec_ch ();
  iog_img_if #(.W(W)) orbit_ch ();

  icosahedral_orbit_generator #(.COMP_WIDTH(W)) dut (
    .clk  (clk),
    .rst  (rst),
    .vec  (vec_ch),
    .orbit(orbit_ch)
  );

  iog_orbit_checker orbit_check (
    .clk     (clk),
    .rst     (rst),
    .vec     (vec_ch),
    .orbit   (orbit_ch),
    .failures(failures),
    .pending (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Mostly no gap, else short gaps, a few long ones, and calm stretches with none at all.
  function automatic int unsigned pick_gap(inout bit calm);
    int unsigned roll;
    if ($urandom_range(0, 39) == 0) begin
      calm = !calm;
    end
    roll = $urandom_range(0, 99);
    if (calm || roll < 60) begin
      return 0;
    end else if (roll < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Valid stays high from one transfer into the next when there is no gap.
  task automatic offer_vector(input image_t v);
    int unsigned gap;
    gap = pick_gap(send_calm);
    if (gap > 0) begin
      vec_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    vec_ch.valid  <= 1'b1;
    vec_ch.comp_0 <= v[0];
    vec_ch.comp_1 <= v[1];
    vec_ch.comp_2 <= v[2];
    vec_ch.comp_3 <= v[3];
    vec_ch.comp_4 <= v[4];
    vec_ch.comp_5 <= v[5];
    do @(posedge clk); while (!vec_ch.ready);
  endtask

  initial begin : cycle_guard
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin : receiver
    int unsigned gap;
    orbit_ch.ready <= 1'b0;
    image_transfers = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      // One long hold lets the block fill up and stall its input.
      if (image_transfers == HOLD_AT) begin
        gap = HOLD_CYCLES;
      end else begin
        gap = pick_gap(recv_calm);
      end
      if (gap > 0) begin
        orbit_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      orbit_ch.ready <= 1'b1;
      do @(posedge clk); while (!orbit_ch.valid);
      image_transfers++;
    end
  end

  initial begin : stimulus
    image_t       directed [$];
    image_t       v;
    logic [W-1:0] pool [8];
    logic [W-1:0] a;
    int unsigned  kind;
    rst           <= 1'b1;
    vec_ch.valid  <= 1'b0;
    vec_ch.comp_0 <= '0;
    vec_ch.comp_1 <= '0;
    vec_ch.comp_2 <= '0;
    vec_ch.comp_3 <= '0;
    vec_ch.comp_4 <= '0;
    vec_ch.comp_5 <= '0;

    // All-equal vectors give the smallest orbits; distinct values the largest.
    directed.insert(directed.size(), '0);
    directed.insert(directed.size(), {6{16'h8000}});
    directed.insert(directed.size(), {6{16'h7FFF}});
    directed.insert(directed.size(), {6{16'hFFFF}});
    directed.insert(directed.size(), {6{16'h0001}});
    directed.insert(directed.size(), {6{16'hAAAA}});
    directed.insert(directed.size(), {6{16'h5555}});
    for (int k = 0; k < DIM; k++) begin
      v = '0;
      v[k] = 16'h0100;
      directed.insert(directed.size(), v);
    end
    v = '0;
    v[0] = 16'h8000;
    directed.insert(directed.size(), v);
    v = '0;
    v[3] = 16'h8000;
    directed.insert(directed.size(), v);
    directed.insert(directed.size(),
                    {16'h0006, 16'h0005, 16'h0004, 16'h0003, 16'h0002, 16'h0001});
    directed.insert(directed.size(),
                    {16'h0100, 16'hFFFF, 16'h0001, 16'h0000, 16'h8000, 16'h7FFF});
    // A saturated negation can make two images equal.
    directed.insert(directed.size(),
                    {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000});
    directed.insert(directed.size(),
                    {16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF});
    directed.insert(directed.size(),
                    {16'h7FFF, 16'h8001, 16'h8000, 16'h0000, 16'h7FFF, 16'h8001});

    pool = '{16'h0000, 16'h0001, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h0100, 16'hFF00,
             16'h0000};

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      offer_vector(directed[i]);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      kind    = $urandom_range(0, 99);
      pool[7] = W'($urandom);
      a       = W'($urandom);
      if (kind < 35) begin
        for (int r = 0; r < DIM; r++) begin
          v[r] = W'($urandom);
        end
      end else if (kind < 70) begin
        for (int r = 0; r < DIM; r++) begin
          v[r] = pool[$urandom_range(0, 7)];
        end
      end else if (kind < 85) begin
        for (int r = 0; r < DIM; r++) begin
          v[r] = a;
        end
        if ($urandom_range(0, 1) == 1) begin
          v[$urandom_range(0, DIM - 1)] = pool[$urandom_range(0, 7)];
        end
      end else begin
        if ($urandom_range(0, 3) == 0) begin
          a = 16'h8000;
        end
        for (int r = 0; r < DIM; r++) begin
          v[r] = ($urandom_range(0, 1) == 1) ? a : -a;
        end
      end
      offer_vector(v);
    end
    vec_ch.valid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
